[sv/aps_pkg.sv]
package aps_pkg;

  localparam int unsigned CW = 13;
  localparam int unsigned RW = 17;
  localparam int unsigned SYM_X = 22;
  localparam int unsigned SYM_STOP = 23;

  // classified column handed from front to back
  typedef struct packed {
    logic       qg;
    logic       sg;
    logic       ident;
    logic       simpos;
    logic       last;
  } col_t;

  typedef logic [23:0] brow_t;

  // positive-score bitmap of BLOSUM62, bit j of row i set when score(i,j) > 0
  function automatic brow_t blosum_pos(input logic [4:0] r);
    brow_t v;
    v = '0;
    case (r)
      5'd0:  v = 24'b000000001000000000000001;
      5'd1:  v = 24'b000000000000100000100010;
      5'd2:  v = 24'b000100001000000100001100;
      5'd3:  v = 24'b001100000000000001001100;
      5'd4:  v = 24'b000000000000000000010000;
      5'd5:  v = 24'b001000000000100001100010;
      5'd6:  v = 24'b001100000000100001101000;
      5'd7:  v = 24'b000000000000000010000000;
      5'd8:  v = 24'b000001000000000100000100;
      5'd9:  v = 24'b000010000001011000000000;
      5'd10: v = 24'b000010000001011000000000;
      5'd11: v = 24'b001000000000100001100010;
      5'd12: v = 24'b000010000001011000000000;
      5'd13: v = 24'b000001100010000000000000;
      5'd14: v = 24'b000000000100000000000000;
      5'd15: v = 24'b000000011000000000000101;
      5'd16: v = 24'b000000011000000000000000;
      5'd17: v = 24'b000001100010000000000000;
      5'd18: v = 24'b000001100010000100000000;
      5'd19: v = 24'b000010000001011000000000;
      5'd20: v = 24'b001100000000000001001100;
      5'd21: v = 24'b001100000000100001101000;
      5'd22: v = 24'b000000000000000000000000;
      5'd23: v = 24'b100000000000000000000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] row_of(input logic [7:0] c);
    logic [7:0] u;
    logic [4:0] r;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    r = 5'(SYM_X);
    if (c == 8'h2a) r = 5'(SYM_STOP);
    else begin
      case (u)
        8'h41: r = 5'd0;  8'h42: r = 5'd20; 8'h43: r = 5'd4;  8'h44: r = 5'd3;
        8'h45: r = 5'd6;  8'h46: r = 5'd13; 8'h47: r = 5'd7;  8'h48: r = 5'd8;
        8'h49: r = 5'd9;  8'h4b: r = 5'd11; 8'h4c: r = 5'd10; 8'h4d: r = 5'd12;
        8'h4e: r = 5'd2;  8'h50: r = 5'd14; 8'h51: r = 5'd5;  8'h52: r = 5'd1;
        8'h53: r = 5'd15; 8'h54: r = 5'd16; 8'h56: r = 5'd19; 8'h57: r = 5'd17;
        8'h58: r = 5'd22; 8'h59: r = 5'd18; 8'h5a: r = 5'd21;
        default: r = 5'(SYM_X);
      endcase
    end
    return r;
  endfunction

  function automatic logic gap_char(input logic [7:0] c);
    return c == 8'h2d || c == 8'h7e || c == 8'h2e || c == 8'h5f;
  endfunction

  function automatic logic [15:0] thr_rom(input logic [6:0] k);
    logic [15:0] v;
    case (k)
      7'd0: v = 16'd55409; 7'd1: v = 16'd52690; 7'd2: v = 16'd50331; 7'd3: v = 16'd48262;
      7'd4: v = 16'd46427; 7'd5: v = 16'd44786; 7'd6: v = 16'd43307; 7'd7: v = 16'd41966;
      7'd8: v = 16'd40743; 7'd9: v = 16'd39622; 7'd10: v = 16'd38589; 7'd11: v = 16'd37634;
      7'd12: v = 16'd36747; 7'd13: v = 16'd35921; 7'd14: v = 16'd35150;
      7'd15: v = 16'd34427; 7'd16: v = 16'd33748; 7'd17: v = 16'd33108;
      7'd18: v = 16'd32505; 7'd19: v = 16'd31934; 7'd20: v = 16'd31393;
      7'd21: v = 16'd30880; 7'd22: v = 16'd30392; 7'd23: v = 16'd29927;
      7'd24: v = 16'd29483; 7'd25: v = 16'd29060; 7'd26: v = 16'd28655;
      7'd27: v = 16'd28267; 7'd28: v = 16'd27895; 7'd29: v = 16'd27539;
      7'd30: v = 16'd27196; 7'd31: v = 16'd26866; 7'd32: v = 16'd26549;
      7'd33: v = 16'd26243; 7'd34: v = 16'd25948; 7'd35: v = 16'd25664;
      7'd36: v = 16'd25389; 7'd37: v = 16'd25123; 7'd38: v = 16'd24866;
      7'd39: v = 16'd24618; 7'd40: v = 16'd24377; 7'd41: v = 16'd24143;
      7'd42: v = 16'd23917; 7'd43: v = 16'd23697; 7'd44: v = 16'd23484;
      7'd45: v = 16'd23276; 7'd46: v = 16'd23075; 7'd47: v = 16'd22879;
      7'd48: v = 16'd22688; 7'd49: v = 16'd22503; 7'd50: v = 16'd22322;
      7'd51: v = 16'd22146; 7'd52: v = 16'd21974; 7'd53: v = 16'd21807;
      7'd54: v = 16'd21643; 7'd55: v = 16'd21484; 7'd56: v = 16'd21329;
      7'd57: v = 16'd21177; 7'd58: v = 16'd21028; 7'd59: v = 16'd20883;
      7'd60: v = 16'd20741; 7'd61: v = 16'd20603; 7'd62: v = 16'd20467;
      7'd63: v = 16'd20334; 7'd64: v = 16'd20204; 7'd65: v = 16'd20077;
      7'd66: v = 16'd19953; 7'd67: v = 16'd19830; 7'd68: v = 16'd19711;
      7'd69: v = 16'd19594; 7'd70: v = 16'd19479;
      default: v = 16'd19479;
    endcase
    return v;
  endfunction

endpackage

[sv/aps_front.sv]
module aps_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       query_residue,
  input  logic [7:0]       subject_residue,
  input  logic             last_column,
  output logic             q_valid,
  input  logic             q_stall,
  output aps_pkg::col_t    q_col
);

  logic          full_r;
  aps_pkg::col_t col_r;
  aps_pkg::col_t col_nxt;
  aps_pkg::brow_t brow;
  logic [4:0]    rq;
  logic [4:0]    rs;

  assign in_stall = full_r && q_stall;
  assign q_valid  = full_r;
  assign q_col    = col_r;

  always_comb begin
    rq = aps_pkg::row_of(query_residue);
    rs = aps_pkg::row_of(subject_residue);
    brow = aps_pkg::blosum_pos(rq);
    col_nxt.qg     = aps_pkg::gap_char(query_residue);
    col_nxt.sg     = aps_pkg::gap_char(subject_residue);
    col_nxt.ident  = query_residue == subject_residue;
    col_nxt.simpos = brow[rs];
    col_nxt.last   = last_column;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (!in_stall) begin
      full_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      col_r <= col_nxt;
    end
  end

  // a held word must stay while the queue stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_stall |=> q_valid && $stable(q_col))
    else $error("front word changed under stall");

endmodule

[sv/aps_back.sv]
module aps_back #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_stall,
  input  aps_pkg::col_t q_col,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [12:0]   out_first_aligned,
  output logic [12:0]   out_last_aligned,
  output logic [12:0]   out_aligned_length,
  output logic [12:0]   out_gap_openings,
  output logic [12:0]   out_gap_columns,
  output logic [12:0]   out_identical_count,
  output logic [12:0]   out_similar_count,
  output logic [16:0]   out_identity_ratio,
  output logic [16:0]   out_similarity_ratio,
  output logic          out_above_threshold,
  output logic          out_error_code
);

  localparam int unsigned W = $clog2(MAX_COLUMNS + 1) + 1;
  localparam int unsigned DW = $clog2(W + 18);
  localparam logic [W-1:0] MAXC = W'(MAX_COLUMNS);
  localparam logic [W+16:0] QONE = (W+17)'(65536);
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0]   st_r;
  logic [W-1:0] cc_r, lead_r, cg_r, op_r, gc_r, id_r, sm_r, pt_r, pc_r, pg_r;
  logic         inlead_r, pwg_r, po_r, err_r;
  logic [W-1:0] cc_nxt, lead_nxt, cg_nxt, op_nxt, gc_nxt, id_nxt, sm_nxt;
  logic [W-1:0] pt_nxt, pc_nxt, pg_nxt;
  logic         inlead_nxt, pwg_nxt, po_nxt, err_nxt;
  logic         take;

  // division unit: restoring, one quotient bit a cycle for both ratios
  logic [W-1:0] den_r;
  logic [W:0]   rem_i_r, rem_s_r;
  logic [W+16:0] num_i_r, num_s_r;
  logic [W+16:0] qi_r, qs_r;
  logic [DW-1:0] dcnt_r;
  logic [W-1:0] lali_r, lastal_r;
  logic [W:0]   ri_sh, rs_sh;

  function automatic logic [W-1:0] sat(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, MAXC}) ? MAXC : s[W-1:0];
  endfunction

  assign take    = q_valid && !q_stall;
  assign q_stall = st_r != ST_RUN;

  always_comb begin
    cc_nxt = cc_r; lead_nxt = lead_r; cg_nxt = cg_r; op_nxt = op_r; gc_nxt = gc_r;
    id_nxt = id_r; sm_nxt = sm_r; pt_nxt = pt_r; pc_nxt = pc_r; pg_nxt = pg_r;
    inlead_nxt = inlead_r; pwg_nxt = pwg_r; po_nxt = po_r; err_nxt = err_r;
    if (cc_r == '0 && q_col.qg) err_nxt = 1'b1;
    if (q_col.last && q_col.qg) err_nxt = 1'b1;
    cc_nxt = sat(cc_r, W'(1));
    if (inlead_r && q_col.sg) begin
      lead_nxt = sat(lead_r, W'(1));
    end else if (q_col.sg) begin
      pt_nxt = sat(pt_r, W'(1));
      if (q_col.qg) begin
        pc_nxt = sat(pc_r, W'(1));
      end else begin
        if (!pwg_r && pg_r == '0) po_nxt = 1'b1;
        pg_nxt = sat(pg_r, W'(1));
      end
    end else begin
      inlead_nxt = 1'b0;
      cg_nxt = sat(cg_r, pc_r);
      gc_nxt = sat(gc_r, pg_r);
      op_nxt = po_r ? sat(op_r, W'(1)) : op_r;
      pwg_nxt = pwg_r || (pg_r != '0);
      pt_nxt = '0; pc_nxt = '0; pg_nxt = '0; po_nxt = 1'b0;
      if (q_col.qg) begin
        if (!pwg_nxt) op_nxt = sat(op_nxt, W'(1));
        pwg_nxt = 1'b1;
        gc_nxt = sat(gc_nxt, W'(1));
      end else begin
        pwg_nxt = 1'b0;
        if (q_col.ident) begin
          id_nxt = sat(id_r, W'(1));
          sm_nxt = sat(sm_r, W'(1));
        end else if (q_col.simpos) begin
          sm_nxt = sat(sm_r, W'(1));
        end
      end
    end
  end

  assign ri_sh = {rem_i_r[W-1:0], num_i_r[W+16]};
  assign rs_sh = {rem_s_r[W-1:0], num_s_r[W+16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
      cc_r <= '0; lead_r <= '0; cg_r <= '0; op_r <= '0; gc_r <= '0;
      id_r <= '0; sm_r <= '0; pt_r <= '0; pc_r <= '0; pg_r <= '0;
      inlead_r <= 1'b1; pwg_r <= 1'b1; po_r <= 1'b0; err_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      case (st_r)
        ST_RUN: begin
          if (take) begin
            cc_r <= cc_nxt; lead_r <= lead_nxt; cg_r <= cg_nxt; op_r <= op_nxt;
            gc_r <= gc_nxt; id_r <= id_nxt; sm_r <= sm_nxt; pt_r <= pt_nxt;
            pc_r <= pc_nxt; pg_r <= pg_nxt; inlead_r <= inlead_nxt; pwg_r <= pwg_nxt;
            po_r <= po_nxt; err_r <= err_nxt;
            if (q_col.last) begin
              st_r <= ST_DIV;
              lali_r <= (cc_nxt > cg_nxt) ? cc_nxt - cg_nxt : '0;
              den_r <= (cc_nxt > cg_nxt) ? cc_nxt - cg_nxt : '0;
              lastal_r <= (cc_nxt > pt_nxt) ? cc_nxt - pt_nxt : '0;
              num_i_r <= {id_nxt, 17'd0} >> 1;
              num_s_r <= {sm_nxt, 17'd0} >> 1;
              rem_i_r <= '0; rem_s_r <= '0;
              dcnt_r <= DW'(W + 17);
            end
          end
        end
        ST_DIV: begin
          num_i_r <= num_i_r << 1;
          num_s_r <= num_s_r << 1;
          if (ri_sh >= {1'b0, den_r}) begin
            rem_i_r <= ri_sh - {1'b0, den_r}; qi_r <= {qi_r[W+15:0], 1'b1};
          end else begin
            rem_i_r <= ri_sh; qi_r <= {qi_r[W+15:0], 1'b0};
          end
          if (rs_sh >= {1'b0, den_r}) begin
            rem_s_r <= rs_sh - {1'b0, den_r}; qs_r <= {qs_r[W+15:0], 1'b1};
          end else begin
            rem_s_r <= rs_sh; qs_r <= {qs_r[W+15:0], 1'b0};
          end
          dcnt_r <= dcnt_r - DW'(1);
          if (dcnt_r == DW'(1)) st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            st_r <= ST_RUN;
            cc_r <= '0; lead_r <= '0; cg_r <= '0; op_r <= '0; gc_r <= '0;
            id_r <= '0; sm_r <= '0; pt_r <= '0; pc_r <= '0; pg_r <= '0;
            inlead_r <= 1'b1; pwg_r <= 1'b1; po_r <= 1'b0; err_r <= 1'b0;
          end
        end
        default: st_r <= ST_RUN;
      endcase
    end
  end

  logic [6:0]  lidx;
  logic [16:0] ide_c, sim_c;

  // quotient only ever exceeds one when counts saturate; clamp to 1.0
  assign ide_c = (lali_r == '0) ? 17'd0 : (qi_r > QONE ? 17'd65536 : qi_r[16:0]);
  assign sim_c = (lali_r == '0) ? 17'd0 : (qs_r > QONE ? 17'd65536 : qs_r[16:0]);
  assign lidx  = (lali_r < W'(10)) ? 7'd0 : (lali_r > W'(80)) ? 7'd70 : 7'(lali_r - W'(10));

  assign out_valid            = st_r == ST_OUT;
  assign out_first_aligned    = 13'(lead_r + W'(1));
  assign out_last_aligned     = 13'(lastal_r);
  assign out_aligned_length   = 13'(lali_r);
  assign out_gap_openings     = 13'(op_r);
  assign out_gap_columns      = 13'(gc_r);
  assign out_identical_count  = 13'(id_r);
  assign out_similar_count    = 13'(sm_r);
  assign out_identity_ratio   = ide_c;
  assign out_similarity_ratio = sim_c;
  assign out_above_threshold  = !err_r && ({1'b0, aps_pkg::thr_rom(lidx)} < ide_c);
  assign out_error_code       = err_r;

  a_nostall_run: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN |-> !q_stall)
    else $error("queue stalled while running");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r <= MAXC && id_r <= sm_r)
    else $error("counter out of range");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV && dcnt_r == DW'(1) |=> out_valid)
    else $error("divider did not finish");

endmodule

[sv/alignment_pair_statistics.sv]
// Alignment pair statistics.
// Input channel: one alignment column per word (query and subject ASCII
// characters, last_column flag), in_valid / in_stall. Gap chars: - ~ . _
// Output channel: one word per pair, issued after the column flagged last,
// out_valid / out_stall; all counts, Q1.16 identity and similarity ratios,
// threshold verdict and query-edge error.
// A front register classifies each column (gap tests, identity, BLOSUM62
// positive lookup); the back end updates the counters at one column per
// cycle while it runs. After the last column a restoring divider produces
// both ratios, one quotient bit a cycle, during which the back end stalls
// the front register. The last column passes through the front register,
// the counters, the divider and the output state to the result.
// The result holds while out_stall is high; the front register keeps one
// more column, then in_stall rises.
// Reset (synchronous, rst_n low) clears all counters and empties both
// stages; after each result the counters return to that state.
module alignment_pair_statistics #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_query_residue,
  input  logic [7:0]  in_subject_residue,
  input  logic        in_last_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_first_aligned,
  output logic [12:0] out_last_aligned,
  output logic [12:0] out_aligned_length,
  output logic [12:0] out_gap_openings,
  output logic [12:0] out_gap_columns,
  output logic [12:0] out_identical_count,
  output logic [12:0] out_similar_count,
  output logic [16:0] out_identity_ratio,
  output logic [16:0] out_similarity_ratio,
  output logic        out_above_threshold,
  output logic        out_error_code
);

  logic          q_valid;
  logic          q_stall;
  aps_pkg::col_t q_col;

  aps_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .query_residue(in_query_residue), .subject_residue(in_subject_residue),
    .last_column(in_last_column),
    .q_valid(q_valid), .q_stall(q_stall), .q_col(q_col)
  );

  aps_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_stall(q_stall), .q_col(q_col),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_aligned(out_first_aligned), .out_last_aligned(out_last_aligned),
    .out_aligned_length(out_aligned_length), .out_gap_openings(out_gap_openings),
    .out_gap_columns(out_gap_columns), .out_identical_count(out_identical_count),
    .out_similar_count(out_similar_count), .out_identity_ratio(out_identity_ratio),
    .out_similarity_ratio(out_similarity_ratio),
    .out_above_threshold(out_above_threshold), .out_error_code(out_error_code)
  );

endmodule
